>>> design/bitmap_block_allocator_defines.svh
// Assertion macros used by the allocator sequencer.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bba_pkg.sv
package bba_pkg;

	// Field widths
	localparam int BN_W   = 13;
	localparam int STAT_W = 2;
	localparam int BYTE_W = 8;

	// Default geometry
	localparam int BYTES_PER_MAP_BLOCK_DEF = 512;
	localparam int MAP_BLOCKS_DEF          = 1;

	// Operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// Result of one item
	typedef struct packed {
		logic [BN_W-1:0]   blk;
		logic [STAT_W-1:0] status;
		logic              map_blk;
		logic              changed;
	} res_t;

	// Index of the lowest clear bit of a byte
	function automatic logic [2:0] first_zero(input logic [BYTE_W-1:0] v);
		logic [2:0] idx;
		idx = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (!v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

endpackage

>>> design/bitmap_block_allocator.sv
// Sequence: an allocate scans the bitmap RAM from its first byte up to the first byte with
// a clear bit and sets that bit, then repeated subtraction finds the bitmap block; a free
// reads the byte, clears the bit and then finds the bitmap block; a free out of range does not.
// Throughput: one item at a time, bounded by the byte-per-cycle scan of the bitmap RAM.
// Full bitmap: an allocate scans every byte and returns the full status.
// Reset: asynchronous; a clearing pass then writes every bitmap byte to free,
// with req_stall high throughout.
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int BYTES_PER_MAP_BLOCK = BYTES_PER_MAP_BLOCK_DEF,
	parameter int MAP_BLOCKS          = MAP_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              operation,
	input  logic [BN_W-1:0]   block_number,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [BN_W-1:0]   allocated_block,
	output logic [STAT_W-1:0] status,
	output logic              changed_bitmap_block,
	output logic              bitmap_changed
);

	logic res_valid;
	res_t res;
	logic res_take;
	logic rsp_valid_q;
	res_t rsp_q;

	bba_seq #(
		.BYTES_PER_MAP_BLOCK (BYTES_PER_MAP_BLOCK),
		.MAP_BLOCKS          (MAP_BLOCKS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.block_number (block_number),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	// Output register: takes a new item when empty or being drained
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) rsp_q <= res;
	end

	assign rsp_valid            = rsp_valid_q;
	assign allocated_block      = rsp_q.blk;
	assign status               = rsp_q.status;
	assign changed_bitmap_block = rsp_q.map_blk;
	assign bitmap_changed       = rsp_q.changed;

endmodule

>>> design/bba_ram.sv
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/bba_seq.sv
`include "bitmap_block_allocator_defines.svh"

module bba_seq import bba_pkg::*; #(
	parameter int BYTES_PER_MAP_BLOCK = BYTES_PER_MAP_BLOCK_DEF,
	parameter int MAP_BLOCKS          = MAP_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            operation,
	input  logic [BN_W-1:0] block_number,
	output logic            res_valid,
	output res_t            res,
	input  logic            res_take
);

	localparam int DEPTH     = BYTES_PER_MAP_BLOCK * MAP_BLOCKS;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OFF_W     = ADDR_W + 3;
	localparam int DATA_BITS = DEPTH * 8;
	localparam int BASE      = 2 + MAP_BLOCKS;
	localparam int DW        = ((OFF_W > BN_W) ? OFF_W : BN_W) + 1;
	localparam int SW        = ((OFF_W + 1) > BN_W) ? (OFF_W + 1) : BN_W;
	localparam int IW        = ADDR_W + 1;

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		SCAN,
		FREE_RD,
		FREE_WR,
		DIVIDE,
		DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [IW-1:0]       issue_q;
	logic                chk_valid_q;
	logic [ADDR_W-1:0]   chk_addr_q;
	logic [OFF_W-1:0]    off_q;
	logic [IW-1:0]       rem_q;
	res_t                res_q;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [BYTE_W-1:0]   wr_data;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [BYTE_W-1:0]   rd_data;

	logic [DW-1:0]       diff;
	logic                bad;
	logic [2:0]          first;
	logic                found;
	logic [SW-1:0]       sum;
	logic                last_chk;

	bba_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Free request: offset and range check
	assign diff = DW'(block_number) - DW'(BASE);
	assign bad  = (DW'(block_number) < DW'(BASE)) || (diff >= DW'(DATA_BITS));

	// Byte checker: the checking unit of the scan
	assign first    = first_zero(rd_data);
	assign found    = chk_valid_q && (rd_data != {BYTE_W{1'b1}});
	assign sum      = SW'({chk_addr_q, first}) + SW'(BASE);
	assign last_chk = chk_valid_q && (chk_addr_q == ADDR_W'(DEPTH - 1));

	// Memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = issue_q[ADDR_W-1:0];
		case (state_q)
			CLEAR: begin
				wr_en = 1'b1;
			end
			SCAN: begin
				rd_en = (issue_q < IW'(DEPTH));
				if (found) begin
					wr_en   = 1'b1;
					wr_addr = chk_addr_q;
					wr_data = rd_data | (BYTE_W'(1) << first);
				end
			end
			FREE_RD: begin
				rd_en   = 1'b1;
				rd_addr = off_q[OFF_W-1:3];
			end
			FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = off_q[OFF_W-1:3];
				wr_data = rd_data & ~(BYTE_W'(1) << off_q[2:0]);
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			clr_q       <= '0;
			issue_q     <= '0;
			chk_valid_q <= 1'b0;
			chk_addr_q  <= '0;
			off_q       <= '0;
			rem_q       <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) state_q <= IDLE;
				end
				IDLE: begin
					if (req_valid) begin
						if (operation == OP_ALLOC) begin
							issue_q     <= '0;
							chk_valid_q <= 1'b0;
							state_q     <= SCAN;
						end else if (bad) begin
							res_q   <= '{blk: '0, status: STAT_RANGE, map_blk: 1'b0,
								changed: 1'b0};
							state_q <= DONE;
						end else begin
							off_q   <= diff[OFF_W-1:0];
							state_q <= FREE_RD;
						end
					end
				end
				SCAN: begin
					if (rd_en) issue_q <= issue_q + 1'b1;
					chk_valid_q <= rd_en;
					chk_addr_q  <= issue_q[ADDR_W-1:0];
					if (found) begin
						res_q   <= '{blk: sum[BN_W-1:0], status: STAT_OK, map_blk: 1'b0,
							changed: 1'b1};
						rem_q   <= IW'(chk_addr_q);
						state_q <= DIVIDE;
					end else if (last_chk) begin
						res_q   <= '{blk: '0, status: STAT_FULL, map_blk: 1'b0,
							changed: 1'b0};
						state_q <= DONE;
					end
				end
				FREE_RD: begin
					state_q <= FREE_WR;
				end
				FREE_WR: begin
					res_q   <= '{blk: '0, status: STAT_OK, map_blk: 1'b0, changed: 1'b1};
					rem_q   <= IW'(off_q[OFF_W-1:3]);
					state_q <= DIVIDE;
				end
				DIVIDE: begin
					// repeated subtract; only the parity of the quotient is kept
					if (rem_q >= IW'(BYTES_PER_MAP_BLOCK)) begin
						rem_q         <= rem_q - IW'(BYTES_PER_MAP_BLOCK);
						res_q.map_blk <= ~res_q.map_blk;
					end else begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (res_take) state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != IDLE);
	assign res_valid = (state_q == DONE);
	assign res       = res_q;

	`BBA_ASSERT_NOW(a_scan_sets_one, (state_q == SCAN) && wr_en, $countones(wr_data) == $countones(rd_data) + 1, "allocate write must set exactly one bit")
	`BBA_ASSERT_NOW(a_free_only_clears, state_q == FREE_WR, (wr_data & ~rd_data) == '0, "free write must not set a bit")
	`BBA_ASSERT_NOW(a_ok_marks_dirty, res_valid && (res_q.status == STAT_OK), res_q.changed, "ok result must flag a bitmap change")
	`BBA_ASSERT_NEXT(a_accept_leaves_idle, (state_q == IDLE) && req_valid, state_q != IDLE, "accepted item must start work")

endmodule

>>> bench/allocation_checker.sv
`timescale 1ns / 100ps

module allocation_checker import bba_pkg::*; #(
	parameter int BYTES_PER_MAP_BLOCK = BYTES_PER_MAP_BLOCK_DEF,
	parameter int MAP_BLOCKS          = MAP_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic              operation,
	input  logic [BN_W-1:0]   block_number,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [BN_W-1:0]   allocated_block,
	input  logic [STAT_W-1:0] status,
	input  logic              changed_bitmap_block,
	input  logic              bitmap_changed,
	output int                fail_count,
	output int                outstanding
);

	localparam int BITS_PER_MAP = BYTES_PER_MAP_BLOCK * BYTE_W;
	localparam int MAP_BITS     = BITS_PER_MAP * MAP_BLOCKS;
	localparam int BLOCK_BASE   = 2 + MAP_BLOCKS;

	// shadow copy of the usage bitmap, one entry per data block
	logic block_used [MAP_BITS];
	res_t pending_results [$];

	// first-fit allocate or free against the shadow bitmap
	function automatic res_t predict_allocation(input logic op, input logic [BN_W-1:0] bn);
		res_t r;
		int off;
		logic found;
		r = '0;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			r.status = STAT_FULL;
			for (off = 0; off < MAP_BITS && !found; off++) begin
				if (!block_used[off]) begin
					found = 1'b1;
					block_used[off] = 1'b1;
					r.blk     = BN_W'(BLOCK_BASE + off);
					r.status  = STAT_OK;
					r.map_blk = 1'(off / BITS_PER_MAP);
					r.changed = 1'b1;
				end
			end
		end else if (int'(bn) < BLOCK_BASE || int'(bn) - BLOCK_BASE >= MAP_BITS) begin
			r.status = STAT_RANGE;
		end else begin
			// freeing an already free block still counts as a write
			off = int'(bn) - BLOCK_BASE;
			block_used[off] = 1'b0;
			r.map_blk = 1'(off / BITS_PER_MAP);
			r.changed = 1'b1;
		end
		return r;
	endfunction

	function automatic int field_mismatch(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// watch both channels; results are matched before new items are queued
	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < MAP_BITS; i++) block_used[i] = 1'b0;
			pending_results.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected, actual blk %0d status %0d",
						$time, allocated_block, status);
					errs++;
				end else begin
					want = pending_results.pop_front();
					errs += field_mismatch("allocated_block", want.blk, allocated_block);
					errs += field_mismatch("status", want.status, status);
					errs += field_mismatch("changed_bitmap_block", want.map_blk,
						changed_bitmap_block);
					errs += field_mismatch("bitmap_changed", want.changed, bitmap_changed);
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(predict_allocation(operation, block_number));
			fail_count  <= fail_count + errs;
			outstanding <= pending_results.size();
		end
	end

endmodule

>>> bench/bitmap_block_allocator_tb.sv
`timescale 1ns / 100ps

module bitmap_block_allocator_tb import bba_pkg::*;;

	localparam int BYTES_PER_MAP_BLOCK = BYTES_PER_MAP_BLOCK_DEF;
	localparam int MAP_BLOCKS          = MAP_BLOCKS_DEF;
	localparam int MAP_BITS            = BYTES_PER_MAP_BLOCK * MAP_BLOCKS * BYTE_W;
	localparam int BLOCK_BASE          = 2 + MAP_BLOCKS;
	localparam int LAST_BLOCK          = BLOCK_BASE + MAP_BITS - 1;
	localparam int BN_MAX              = (1 << BN_W) - 1;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              operation;
	logic [BN_W-1:0]   block_number;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [BN_W-1:0]   allocated_block;
	logic [STAT_W-1:0] status;
	logic              changed_bitmap_block;
	logic              bitmap_changed;
	logic              quiet;
	int                fail_count;
	int                outstanding;

	bitmap_block_allocator #(
		.BYTES_PER_MAP_BLOCK(BYTES_PER_MAP_BLOCK),
		.MAP_BLOCKS(MAP_BLOCKS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.block_number(block_number),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.allocated_block(allocated_block),
		.status(status),
		.changed_bitmap_block(changed_bitmap_block),
		.bitmap_changed(bitmap_changed)
	);

	allocation_checker #(
		.BYTES_PER_MAP_BLOCK(BYTES_PER_MAP_BLOCK),
		.MAP_BLOCKS(MAP_BLOCKS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.block_number(block_number),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.allocated_block(allocated_block),
		.status(status),
		.changed_bitmap_block(changed_bitmap_block),
		.bitmap_changed(bitmap_changed),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#60_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stall after each accepted result
	always @(posedge clk or negedge arst_n) begin : result_side
		int unsigned hold;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold = 0;
		end else if (rsp_valid && !rsp_stall) begin
			hold = quiet ? 0 : $urandom_range(16, 0);
			rsp_stall <= (hold != 0);
		end else if (hold != 0) begin
			hold--;
			rsp_stall <= (hold != 0);
		end
	end

	// one request: optional gap, then hold until accepted
	task automatic send_item(input logic op, input logic [BN_W-1:0] bn);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(16, 0);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		operation    <= op;
		block_number <= bn;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// stop sending until every queued item has its result
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// free target: mostly inside a window above the base, some out of range
	function automatic logic [BN_W-1:0] free_target(input int unsigned span);
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 75)
			return BN_W'(BLOCK_BASE + $urandom_range(span - 1, 0));
		if (r < 85)
			return BN_W'($urandom_range(BLOCK_BASE - 1, 0));
		if (r < 92)
			return BN_W'($urandom_range(BN_MAX, LAST_BLOCK + 1));
		return BN_W'($urandom);
	endfunction

	task automatic run_mix(input int count, input int unsigned span, input int unsigned alloc_pct);
		logic op;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				quiet <= ($urandom_range(3, 0) == 0);
			op = ($urandom_range(99, 0) < alloc_pct) ? OP_ALLOC : OP_FREE;
			send_item(op, (op == OP_ALLOC) ? BN_W'($urandom) : free_target(span));
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		operation    <= OP_ALLOC;
		block_number <= '0;
		quiet        <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first allocations, double free, range edges
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, BN_W'(BN_MAX));
		send_item(OP_FREE, BN_W'(BLOCK_BASE));
		send_item(OP_FREE, BN_W'(BLOCK_BASE));
		send_item(OP_ALLOC, BN_W'(BLOCK_BASE));
		send_item(OP_FREE, '0);
		send_item(OP_FREE, BN_W'(BLOCK_BASE - 1));
		send_item(OP_FREE, BN_W'(LAST_BLOCK));
		send_item(OP_FREE, BN_W'(LAST_BLOCK + 1));
		send_item(OP_FREE, BN_W'(BN_MAX));
		send_item(OP_FREE, BN_W'(BLOCK_BASE + 1));
		send_item(OP_ALLOC, BN_W'(LAST_BLOCK));
		send_item(OP_ALLOC, '0);
		drain_results();

		// random mix near the bottom of the bitmap
		run_mix(250, 96, 50);
		drain_results();
		run_mix(250, 96, 50);

		// burst of allocations back to back, then frees at both ends
		quiet <= 1'b1;
		repeat (200) send_item(OP_ALLOC, BN_W'($urandom));
		quiet <= 1'b0;
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, BN_W'(BN_MAX));
		send_item(OP_FREE, BN_W'(LAST_BLOCK));
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_FREE, BN_W'(BLOCK_BASE));
		send_item(OP_ALLOC, '0);

		// random mix over the whole range
		run_mix(230, MAP_BITS, 55);
		drain_results();

		// catch any stray result after the last one
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
